### hdl/sxb_pkg.sv
// Shared types, constants and character helpers for the salted XOR base64 codec.
`default_nettype none
package sxb_pkg;

	localparam int KEY_BYTES_DEF = 8;
	localparam int FIFO_DEPTH    = 2;
	localparam int REC_SLOTS     = 4;

	localparam logic [63:0] KEY_RESET      = 64'h7965_6B5F_7473_6574;
	localparam logic [3:0]  KEY_LEN_RESET  = 4'd8;
	localparam logic [5:0]  SALT_LEN_RESET = 6'd32;

	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	localparam logic [1:0] REG_MODE     = 2'd0;
	localparam logic [1:0] REG_KEY      = 2'd1;
	localparam logic [1:0] REG_KEY_LEN  = 2'd2;
	localparam logic [1:0] REG_SALT_LEN = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_LENGTH   = 2'd1;
	localparam logic [1:0] ST_BAD_CHAR = 2'd2;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       out_last;
		logic [1:0] status;
	} result_t;

	typedef struct packed {
		logic [REC_SLOTS-1:0][7:0] bytes;
		logic [2:0]                cnt;
		logic                      has_byte;
		logic                      last;
		logic [1:0]                status;
	} rec_t;

	typedef struct packed {
		logic       mode;
		logic [3:0] key_len;
		logic [5:0] salt_len;
	} cfg_t;

	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		logic [7:0] r;
		if (v < 6'd26) begin
			r = 8'h41 + {2'b00, v};
		end else if (v < 6'd52) begin
			r = {2'b00, v} + 8'd71;
		end else if (v < 6'd62) begin
			r = {2'b00, v} - 8'd4;
		end else if (v == 6'd62) begin
			r = 8'h2B;
		end else begin
			r = 8'h2F;
		end
		return r;
	endfunction

	// bit 6 flags a character outside the alphabet
	function automatic logic [6:0] char_sextet(input logic [7:0] c);
		logic [6:0] r;
		if (c inside {[8'h41:8'h5A]}) begin
			r = {1'b0, 6'(c - 8'h41)};
		end else if (c inside {[8'h61:8'h7A]}) begin
			r = {1'b0, 6'(c - 8'h47)};
		end else if (c inside {[8'h30:8'h39]}) begin
			r = {1'b0, 6'(c + 8'd4)};
		end else if (c == 8'h2B) begin
			r = {1'b0, 6'd62};
		end else if (c == 8'h2F) begin
			r = {1'b0, 6'd63};
		end else begin
			r = {1'b1, 6'd0};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### hdl/salted_xor_base64_codec_core.sv
// Top level of the salted XOR base64 codec: register port, front end, queue, back end.
// Path: records pass the queue, the back end's record register and the output register.
// Throughput: one item per cycle into the front end while the queue is not full, one
// result per cycle out of the back end while results are popped; an encode group of
// three bytes gives four results, so bursts wait on the single-result output register.
// Reset: arst_n clears message state and queues and loads register defaults at once.
`default_nettype none
module salted_xor_base64_codec_core #(
	parameter int KEY_BYTES = sxb_pkg::KEY_BYTES_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire sxb_pkg::item_t   item,
	output logic                  empty,
	input  wire logic             pop,
	output sxb_pkg::result_t      result,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [4:0]       paddr,
	input  wire logic [63:0]      pwdata,
	output logic [63:0]           prdata,
	output logic                  pready
);

	logic                   mode_q;
	logic [8*KEY_BYTES-1:0] key_q;
	logic [3:0]             key_len_q;
	logic [5:0]             salt_len_q;

	sxb_pkg::cfg_t cfg;
	sxb_pkg::rec_t rec_in;
	sxb_pkg::rec_t rec_out;
	logic          wr_en;
	logic [1:0]    reg_idx;
	logic          accept;
	logic          fifo_push;
	logic          fifo_full;
	logic          fifo_pop;
	logic          fifo_valid;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:3];
	assign wr_en   = psel && penable && pwrite && pready;
	assign accept  = push && !full;
	assign full    = fifo_full;

	assign cfg = {mode_q, key_len_q, salt_len_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= sxb_pkg::MODE_ENCODE;
			key_q      <= sxb_pkg::KEY_RESET[8*KEY_BYTES-1:0];
			key_len_q  <= sxb_pkg::KEY_LEN_RESET;
			salt_len_q <= sxb_pkg::SALT_LEN_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				sxb_pkg::REG_MODE:     mode_q     <= pwdata[0];
				sxb_pkg::REG_KEY:      key_q      <= pwdata[8*KEY_BYTES-1:0];
				sxb_pkg::REG_KEY_LEN:  key_len_q  <= pwdata[3:0];
				sxb_pkg::REG_SALT_LEN: salt_len_q <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			sxb_pkg::REG_MODE:     prdata = {63'd0, mode_q};
			sxb_pkg::REG_KEY:      prdata = 64'(key_q);
			sxb_pkg::REG_KEY_LEN:  prdata = {60'd0, key_len_q};
			sxb_pkg::REG_SALT_LEN: prdata = {58'd0, salt_len_q};
			default:               prdata = 64'd0;
		endcase
	end

	sxb_front #(
		.KEY_BYTES(KEY_BYTES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.key     (key_q),
		.item    (item),
		.accept  (accept),
		.rec     (rec_in),
		.rec_push(fifo_push)
	);

	sxb_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fifo_push),
		.wdata (rec_in),
		.full  (fifo_full),
		.pop   (fifo_pop),
		.rdata (rec_out),
		.valid (fifo_valid)
	);

	sxb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rec_valid(fifo_valid),
		.rec      (rec_out),
		.rec_pop  (fifo_pop),
		.result   (result),
		.empty    (empty),
		.pop      (pop)
	);

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_push |-> !fifo_full)
		else $error("record pushed into a full queue");

	a_marker_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.has_byte || result.out_last))
		else $error("marker result without end flag");

	a_status_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (result.status != sxb_pkg::ST_OK)) |-> result.out_last)
		else $error("error status on a non-final result");

	a_encode_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(fifo_push && (mode_q == sxb_pkg::MODE_ENCODE)) |-> (rec_in.status == sxb_pkg::ST_OK))
		else $error("encode record carries an error status");

endmodule
`default_nettype wire

### hdl/sxb_front.sv
// Front end: accepts items, runs key/group/salt state and builds result records.
`default_nettype none
module sxb_front #(
	parameter int KEY_BYTES = sxb_pkg::KEY_BYTES_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire sxb_pkg::cfg_t          cfg,
	input  wire logic [8*KEY_BYTES-1:0] key,
	input  wire sxb_pkg::item_t         item,
	input  wire logic                   accept,
	output sxb_pkg::rec_t               rec,
	output logic                        rec_push
);

	logic [23:0] gbuf_q;
	logic [1:0]  gcnt_q;
	logic [2:0]  ki_q;
	logic [5:0]  seen_q;
	logic        pad_q;
	logic        stop_q;
	logic        bad_q;

	logic [23:0] gbuf_d;
	logic [1:0]  gcnt_d;
	logic [2:0]  ki_d;
	logic [5:0]  seen_d;
	logic        pad_d;
	logic        stop_d;
	logic        bad_d;

	logic [3:0] eff;

	always_comb begin
		if (cfg.key_len == 4'd0) begin
			eff = 4'd1;
		end else if (cfg.key_len > 4'(KEY_BYTES)) begin
			eff = 4'(KEY_BYTES);
		end else begin
			eff = cfg.key_len;
		end
	end

	function automatic logic [7:0] key_at(input logic [8*KEY_BYTES-1:0] k, input logic [2:0] idx);
		logic [8*KEY_BYTES-1:0] sh;
		sh = k >> {idx, 3'b000};
		return sh[7:0];
	endfunction

	function automatic logic [2:0] key_next(input logic [2:0] idx, input logic [3:0] e);
		logic [2:0] r;
		if (({1'b0, idx} + 4'd1) >= e) begin
			r = 3'd0;
		end else begin
			r = idx + 3'd1;
		end
		return r;
	endfunction

	always_comb begin
		logic [7:0]  b;
		logic [23:0] nb;
		logic [23:0] t;
		logic [2:0]  count;
		logic [6:0]  cs;
		logic        eq;
		logic [1:0]  drops;
		logic [1:0]  nbytes;
		logic [2:0]  n;
		logic [1:0]  st;

		rec          = '0;
		rec.has_byte = 1'b1;
		rec.status   = sxb_pkg::ST_OK;
		gbuf_d = gbuf_q;
		gcnt_d = gcnt_q;
		ki_d   = ki_q;
		seen_d = seen_q;
		pad_d  = pad_q;
		stop_d = stop_q;
		bad_d  = bad_q;
		count  = {1'b0, gcnt_q} + 3'd1;
		n      = 3'd0;
		b      = 8'd0;
		nb     = 24'd0;
		t      = 24'd0;
		cs     = 7'd0;
		eq     = 1'b0;
		drops  = 2'd0;
		nbytes = 2'd0;
		st     = sxb_pkg::ST_OK;

		if (cfg.mode == sxb_pkg::MODE_ENCODE) begin
			b    = item.in_byte ^ key_at(key, ki_q);
			ki_d = key_next(ki_q, eff);
			nb   = {gbuf_q[15:0], b};
			if (count >= 3'd3) begin
				for (int i = 0; i < 4; i++) begin
					rec.bytes[i] = sxb_pkg::sextet_char(nb[18-6*i +: 6]);
				end
				rec.cnt = 3'd4;
				rec.last = item.in_last;
				gbuf_d = 24'd0;
				gcnt_d = 2'd0;
			end else if (item.in_last) begin
				t = (count == 3'd1) ? {nb[7:0], 16'd0} : {nb[15:0], 8'd0};
				for (int i = 0; i < 4; i++) begin
					if (3'(i) <= count) begin
						rec.bytes[i] = sxb_pkg::sextet_char(t[18-6*i +: 6]);
					end else begin
						rec.bytes[i] = sxb_pkg::PAD_CHAR;
					end
				end
				rec.cnt = 3'd4;
				rec.last = 1'b1;
			end else begin
				gbuf_d = nb;
				gcnt_d = count[1:0];
			end
		end else begin
			eq = (item.in_byte == sxb_pkg::PAD_CHAR);
			if (!eq) begin
				cs = sxb_pkg::char_sextet(item.in_byte);
				if (cs[6]) begin
					bad_d = 1'b1;
				end
			end
			nb = {gbuf_q[17:0], cs[5:0]};
			pad_d = (gcnt_q == 2'd2) ? eq : pad_q;
			st = bad_d ? sxb_pkg::ST_BAD_CHAR : sxb_pkg::ST_OK;
			if (count == 3'd4) begin
				drops = item.in_last ? ({1'b0, eq} + {1'b0, pad_d}) : 2'd0;
				nbytes = 2'd3 - drops;
				for (int i = 0; i < 3; i++) begin
					if (2'(i) < nbytes) begin
						b = nb[16-8*i +: 8] ^ key_at(key, ki_d);
						ki_d = key_next(ki_d, eff);
						if (seen_d < cfg.salt_len) begin
							seen_d = seen_d + 6'd1;
						end else if (!stop_d) begin
							if (b == 8'd0) begin
								stop_d = 1'b1;
							end else begin
								rec.bytes[n[1:0]] = b;
								n = n + 3'd1;
							end
						end
					end
				end
				rec.cnt = n;
				if (item.in_last) begin
					rec.last = 1'b1;
					rec.status = st;
					if (n == 3'd0) begin
						rec.cnt = 3'd1;
						rec.has_byte = 1'b0;
					end
				end
				gbuf_d = 24'd0;
				gcnt_d = 2'd0;
				pad_d  = 1'b0;
			end else begin
				gbuf_d = nb;
				gcnt_d = count[1:0];
				if (item.in_last) begin
					rec.cnt = 3'd1;
					rec.has_byte = 1'b0;
					rec.last = 1'b1;
					rec.status = sxb_pkg::ST_LENGTH;
				end
			end
		end

		if (item.in_last) begin
			gbuf_d = 24'd0;
			gcnt_d = 2'd0;
			ki_d   = 3'd0;
			seen_d = 6'd0;
			pad_d  = 1'b0;
			stop_d = 1'b0;
			bad_d  = 1'b0;
		end
	end

	assign rec_push = accept && (rec.cnt != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gbuf_q <= 24'd0;
			gcnt_q <= 2'd0;
			ki_q   <= 3'd0;
			seen_q <= 6'd0;
			pad_q  <= 1'b0;
			stop_q <= 1'b0;
			bad_q  <= 1'b0;
		end else if (accept) begin
			gbuf_q <= gbuf_d;
			gcnt_q <= gcnt_d;
			ki_q   <= ki_d;
			seen_q <= seen_d;
			pad_q  <= pad_d;
			stop_q <= stop_d;
			bad_q  <= bad_d;
		end
	end

endmodule
`default_nettype wire

### hdl/sxb_fifo.sv
// Short record queue between the front end and the back end.
`default_nettype none
module sxb_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire sxb_pkg::rec_t wdata,
	output logic               full,
	input  wire logic          pop,
	output sxb_pkg::rec_t      rdata,
	output logic               valid
);

	localparam int DEPTH = sxb_pkg::FIFO_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	sxb_pkg::rec_t mem [DEPTH];

	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign valid   = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop  = pop && valid;
	assign rdata   = mem[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

### hdl/sxb_back.sv
// Back end: unpacks records into single results behind an output register.
`default_nettype none
module sxb_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             rec_valid,
	input  wire sxb_pkg::rec_t    rec,
	output logic                  rec_pop,
	output sxb_pkg::result_t      result,
	output logic                  empty,
	input  wire logic             pop
);

	sxb_pkg::rec_t    cur_q;
	logic             cur_valid_q;
	logic [1:0]       idx_q;
	sxb_pkg::result_t res_q;
	logic             res_valid_q;

	logic advance;
	logic take;
	logic final_slot;
	logic done;

	assign advance    = !res_valid_q || pop;
	assign take       = advance && cur_valid_q;
	assign final_slot = ({1'b0, idx_q} == (cur_q.cnt - 3'd1));
	assign done       = take && final_slot;
	assign rec_pop    = rec_valid && (!cur_valid_q || done);
	assign result     = res_q;
	assign empty      = !res_valid_q;

	always_ff @(posedge clk) begin
		if (rec_pop) begin
			cur_q <= rec;
		end
		if (take) begin
			res_q.out_byte <= cur_q.bytes[idx_q];
			res_q.has_byte <= cur_q.has_byte;
			res_q.out_last <= final_slot && cur_q.last;
			res_q.status   <= final_slot ? cur_q.status : sxb_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 2'd0;
			res_valid_q <= 1'b0;
		end else begin
			if (rec_pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= 2'd0;
			end else if (done) begin
				cur_valid_q <= 1'b0;
				idx_q       <= 2'd0;
			end else if (take) begin
				idx_q <= idx_q + 2'd1;
			end
			if (take) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

### verif/tb_salted_xor_base64_codec_core.sv
// Self-checking testbench for the salted XOR base64 codec core with result prediction.
module tb_salted_xor_base64_codec_core;
	import sxb_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	item_t       item = '0;
	logic        empty;
	logic        pop = 1'b0;
	result_t     result;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;

	item_t   pending_items[$];
	result_t expected_results[$];
	int      items_queued = 0;
	int      failures = 0;
	int      cycle_count = 0;
	int      send_idle_pct = 0;
	int      recv_idle_pct = 0;
	bit      hold_armed = 1'b0;
	bit      hold_started = 1'b0;
	int      hold_left = 0;

	logic        cfg_mode = MODE_ENCODE;
	logic [63:0] cfg_key = KEY_RESET;
	logic [3:0]  cfg_key_len = KEY_LEN_RESET;
	logic [5:0]  cfg_salt_len = SALT_LEN_RESET;

	logic [23:0] msg_buf = '0;
	logic [1:0]  msg_cnt = '0;
	logic [2:0]  key_idx = '0;
	logic [5:0]  salt_seen = '0;
	logic [1:0]  pad_seen = '0;
	logic        msg_stopped = 1'b0;
	logic        msg_bad = 1'b0;

	salted_xor_base64_codec_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.empty   (empty),
		.pop     (pop),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int eff_key_len(input logic [3:0] kl);
		if (kl == 4'd0) begin
			return 1;
		end
		if (kl > KEY_BYTES_DEF) begin
			return KEY_BYTES_DEF;
		end
		return int'(kl);
	endfunction

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		if (v < 26) begin
			return 8'h41 + v;
		end
		if (v < 52) begin
			return 8'h61 + (v - 26);
		end
		if (v < 62) begin
			return 8'h30 + (v - 52);
		end
		return (v == 62) ? 8'h2B : 8'h2F;
	endfunction

	function automatic int b64_value(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A) begin
			return c - 8'h41;
		end
		if (c >= 8'h61 && c <= 8'h7A) begin
			return c - 8'h61 + 26;
		end
		if (c >= 8'h30 && c <= 8'h39) begin
			return c - 8'h30 + 52;
		end
		if (c == 8'h2B) begin
			return 62;
		end
		if (c == 8'h2F) begin
			return 63;
		end
		return -1;
	endfunction

	function automatic logic [7:0] key_next();
		logic [7:0] kb;
		kb = cfg_key[8 * key_idx +: 8];
		if (int'(key_idx) + 1 >= eff_key_len(cfg_key_len)) begin
			key_idx = '0;
		end else begin
			key_idx = key_idx + 3'd1;
		end
		return kb;
	endfunction

	function automatic void clear_msg();
		msg_buf = '0;
		msg_cnt = '0;
		key_idx = '0;
		salt_seen = '0;
		pad_seen = '0;
		msg_stopped = 1'b0;
		msg_bad = 1'b0;
	endfunction

	function automatic void codec_predict(input item_t it);
		result_t     step_out[$];
		result_t     r;
		logic [23:0] padded;
		logic [7:0]  b;
		logic        is_pad;
		int          sx;
		int          cnt;
		int          nbytes;
		if (cfg_mode == MODE_ENCODE) begin
			b = it.in_byte ^ key_next();
			msg_buf = {msg_buf[15:0], b};
			cnt = msg_cnt + 1;
			if (cnt >= 3) begin
				for (int i = 0; i < 4; i++) begin
					r = '{b64_char(msg_buf[18 - 6 * i +: 6]), 1'b1, it.in_last && i == 3, ST_OK};
					step_out.push_back(r);
				end
				msg_buf = '0;
				msg_cnt = '0;
			end else if (it.in_last) begin
				padded = msg_buf << (8 * (3 - cnt));
				for (int i = 0; i < 4; i++) begin
					r = '{(i <= cnt) ? b64_char(padded[18 - 6 * i +: 6]) : PAD_CHAR,
						1'b1, i == 3, ST_OK};
					step_out.push_back(r);
				end
			end else begin
				msg_cnt = 2'(cnt);
			end
		end else begin
			is_pad = (it.in_byte == PAD_CHAR);
			sx = 0;
			if (!is_pad) begin
				sx = b64_value(it.in_byte);
				if (sx < 0) begin
					msg_bad = 1'b1;
					sx = 0;
				end
			end
			msg_buf = {msg_buf[17:0], 6'(sx)};
			if (msg_cnt == 2'd2) begin
				pad_seen = {1'b0, is_pad};
			end
			cnt = msg_cnt + 1;
			if (cnt == 4) begin
				nbytes = 3 - (it.in_last ? int'(is_pad) + int'(pad_seen[0]) : 0);
				for (int i = 0; i < nbytes; i++) begin
					b = msg_buf[16 - 8 * i +: 8] ^ key_next();
					if (salt_seen < cfg_salt_len) begin
						salt_seen = salt_seen + 6'd1;
					end else if (!msg_stopped) begin
						if (b == 8'h00) begin
							msg_stopped = 1'b1;
						end else begin
							r = '{b, 1'b1, 1'b0, ST_OK};
							step_out.push_back(r);
						end
					end
				end
				msg_buf = '0;
				msg_cnt = '0;
				pad_seen = '0;
				if (it.in_last) begin
					if (step_out.size() == 0) begin
						r = '{8'h00, 1'b0, 1'b0, ST_OK};
						step_out.push_back(r);
					end
					r = step_out.pop_back();
					r.out_last = 1'b1;
					r.status = msg_bad ? ST_BAD_CHAR : ST_OK;
					step_out.push_back(r);
				end
			end else begin
				msg_cnt = 2'(cnt);
				if (it.in_last) begin
					r = '{8'h00, 1'b0, 1'b1, ST_LENGTH};
					step_out.push_back(r);
				end
			end
		end
		if (it.in_last) begin
			clear_msg();
		end
		foreach (step_out[i]) begin
			expected_results.push_back(step_out[i]);
		end
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			failures++;
		end
	endfunction

	always @(posedge clk) begin : drive_proc
		item_t next_item;
		logic  next_push;
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			next_push = push;
			next_item = item;
			if (push && !full) begin
				codec_predict(item);
				next_push = 1'b0;
			end
			if (!next_push && pending_items.size() != 0 &&
				$urandom_range(99) >= send_idle_pct) begin
				next_item = pending_items.pop_front();
				next_push = 1'b1;
			end
			push <= next_push;
			item <= next_item;
		end
	end

	always @(posedge clk) begin : hold_proc
		if (hold_armed && !hold_started) begin
			hold_started <= 1'b1;
			hold_left <= LONG_HOLD;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin : check_proc
		result_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					$error("result transaction with nothing expected: %p", result);
					failures++;
				end else begin
					want = expected_results.pop_front();
					check_field("out_byte", want.out_byte, result.out_byte);
					check_field("has_byte", want.has_byte, result.has_byte);
					check_field("out_last", want.out_last, result.out_last);
					check_field("status", want.status, result.status);
				end
			end
			if (hold_left != 0) begin
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_items.size() != 0 || push || expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_MODE:     cfg_mode = val[0];
			REG_KEY:      cfg_key = val;
			REG_KEY_LEN:  cfg_key_len = val[3:0];
			REG_SALT_LEN: cfg_salt_len = val[5:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic m, input logic [63:0] k, input logic [3:0] kl,
		input logic [5:0] sl);
		reg_write(REG_MODE, {63'd0, m});
		reg_write(REG_KEY, k);
		reg_write(REG_KEY_LEN, {60'd0, kl});
		reg_write(REG_SALT_LEN, {58'd0, sl});
	endtask

	task automatic queue_item(input logic [7:0] b, input logic last);
		pending_items.push_back('{b, last});
		items_queued++;
	endtask

	task automatic queue_text(input string s, input bit ends);
		for (int i = 0; i < s.len(); i++) begin
			queue_item(s[i], ends && i == s.len() - 1);
		end
	endtask

	task automatic queue_list(input logic [7:0] q[$]);
		foreach (q[i]) begin
			queue_item(q[i], i == q.size() - 1);
		end
	endtask

	task automatic queue_encode_msg();
		logic [7:0] plain[$];
		repeat ($urandom_range(9, 1)) plain.push_back(8'($urandom_range(255)));
		queue_list(plain);
	endtask

	task automatic queue_decode_msg();
		logic [7:0]  plain[$];
		logic [7:0]  text[$];
		logic [23:0] grp;
		int          kidx;
		int          eff;
		eff = eff_key_len(cfg_key_len);
		repeat (cfg_salt_len) plain.push_back(8'($urandom_range(255)));
		repeat ($urandom_range(8, 1)) plain.push_back(8'($urandom_range(255, 1)));
		if ($urandom_range(3) == 0) begin
			plain[$urandom_range(plain.size() - 1)] = 8'h00;
		end
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(8, 1)) text.push_back(8'($urandom_range(255)));
		end else begin
			kidx = 0;
			foreach (plain[i]) begin
				plain[i] = plain[i] ^ cfg_key[8 * kidx +: 8];
				kidx = (kidx + 1) % eff;
			end
			for (int i = 0; i < plain.size(); i += 3) begin
				grp = {plain[i],
					(i + 1 < plain.size()) ? plain[i + 1] : 8'h00,
					(i + 2 < plain.size()) ? plain[i + 2] : 8'h00};
				for (int j = 0; j < 4; j++) begin
					text.push_back((i + j - 1 < plain.size()) ?
						b64_char(grp[18 - 6 * j +: 6]) : PAD_CHAR);
				end
			end
			case ($urandom_range(9))
				0: text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
				1: text[$urandom_range(text.size() - 1)] = PAD_CHAR;
				2: void'(text.pop_back());
				3: text.push_back(b64_char(6'($urandom)));
				default: ;
			endcase
		end
		queue_list(text);
	endtask

	initial begin
		int start;
		send_idle_pct = 24;
		recv_idle_pct = 88;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// encode with reset settings: two-byte, one-byte and full final groups
		queue_item(8'h00, 1'b0);
		queue_item(8'hFF, 1'b1);
		queue_item(8'h5A, 1'b1);
		queue_item(8'h01, 1'b0);
		queue_item(8'h80, 1'b0);
		queue_item(8'h7F, 1'b1);
		wait_drained();

		// decode with a clear key: padding, early stop, stray pad, bad char, short length
		set_config(MODE_DECODE, 64'd0, 4'd1, 6'd0);
		queue_text("QQ==", 1'b1);
		queue_text("A=*B", 1'b0);
		queue_text("QUJD", 1'b1);
		queue_text("Q*J", 1'b1);

		for (int ph = 0; ph < 7; ph++) begin
			wait_drained();
			case (ph * 3 / 7)
				0: begin
					send_idle_pct = 24;
					recv_idle_pct = 88;
				end
				1: begin
					send_idle_pct = 88;
					recv_idle_pct = 24;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			case (ph)
				0: set_config(MODE_ENCODE, {$urandom, $urandom}, 4'd8, 6'($urandom));
				1: set_config(MODE_DECODE, '1, 4'd1, 6'd0);
				2: set_config(MODE_DECODE, {$urandom, $urandom}, 4'd15, 6'd63);
				3: set_config(MODE_ENCODE, 64'd0, 4'd0, 6'd0);
				4: set_config(MODE_DECODE, {$urandom, $urandom}, 4'($urandom_range(8, 1)),
					6'($urandom_range(5)));
				5: set_config(MODE_ENCODE, {$urandom, $urandom}, 4'($urandom), 6'($urandom));
				default: set_config(MODE_DECODE, {$urandom, $urandom},
					4'($urandom_range(8, 1)), 6'($urandom_range(3)));
			endcase
			if (ph == 5) begin
				hold_armed = 1'b1;
			end
			start = items_queued;
			while (items_queued - start < ((ph == 2) ? 60 : 15)) begin
				if (cfg_mode == MODE_ENCODE) begin
					queue_encode_msg();
				end else begin
					queue_decode_msg();
				end
			end
			// leave a message open so the next settings apply mid-message
			if (ph == 0 || ph == 3) begin
				repeat ((ph == 0) ? 5 : 2) queue_item(8'($urandom_range(255)), 1'b0);
			end
		end

		wait_drained();
		if (failures == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
